/* rtl/saq_pkg.sv */
// Shared types, constants and step functions for the shortest-arc quaternion core.
// Depends on nothing; imported by shortest_arc_quaternion_core.
package saq_pkg;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int FRAC      = 14;
  localparam int SQ1_STEPS = 32;
  localparam int SQ2_STEPS = 31;
  localparam int DIV_STEPS = 15;

  // Case codes reported with each result item.
  localparam logic [1:0] CODE_GEN   = 2'd0;
  localparam logic [1:0] CODE_ALIGN = 2'd1;
  localparam logic [1:0] CODE_OPP   = 2'd2;
  localparam logic [1:0] CODE_ZERO  = 2'd3;

  localparam logic [OUT_W-1:0] ONE_Q = OUT_W'(1) << FRAC;

  // Partial state of a bit-per-stage square root.
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // Partial state of a bit-per-stage restoring division.
  typedef struct packed {
    logic [45:0] rem;
    logic [14:0] quo;
  } div_t;

  // One root bit: tries (root + 2^k)^2 against what is left of the radicand.
  function automatic sqrt_t sqrt_step(sqrt_t s, int k);
    logic [65:0] cand;
    sqrt_t       o;
    cand = ({34'd0, s.root} << (k + 1)) + (66'd1 << (2 * k));
    o    = s;
    if ({2'b00, s.rem} >= cand) begin
      o.rem  = s.rem - cand[63:0];
      o.root = s.root | (32'd1 << k);
    end
    return o;
  endfunction

  // One quotient bit: subtracts the divisor shifted by k when it fits.
  function automatic div_t div_step(div_t s, logic [30:0] n, int k);
    logic [45:0] cand;
    div_t        o;
    cand = {15'd0, n} << k;
    o    = s;
    if (s.rem >= cand) begin
      o.rem = s.rem - cand;
      o.quo = s.quo | (15'd1 << k);
    end
    return o;
  endfunction

  // Magnitude of a 33-bit signed value.
  function automatic logic [32:0] abs33(logic signed [32:0] v);
    logic [32:0] r;
    r = v[32] ? 33'(-v) : 33'(v);
    return r;
  endfunction

endpackage

/* rtl/shortest_arc_quaternion_core.sv */
// Top level of the shortest-arc quaternion core: a fully pipelined datapath.
// Depends on saq_pkg for codes, types and the square root and divide steps.
//
//  Channel | Ports                        | Contents
//  --------+------------------------------+------------------------------------------
//  input   | in_tvalid/in_tready/in_tdata | from and to vectors, six signed 16-bit
//  result  | out_tvalid/out_tready/       | Q1.14 quaternion in tdata, case code
//          | out_tdata/out_tuser          | in tuser
//
// One item can enter every cycle while the output is not stalled; each item passes from input to
// output register through the two square roots (32 and 31 stages, one root bit each)
// and the 15-stage divider, one quotient bit each.
// Reset (rst_n low, synchronous) clears only the valid bits of every stage.
// Each stage holds its item while the next one is full and stalled, so an empty
// stage always takes a new item and no item is lost or repeated.
module shortest_arc_quaternion_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z (16 bits each, lowest first)
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each, lowest first)
  output logic [63:0] out_tdata,
  // case_code
  output logic [1:0]  out_tuser
);
  import saq_pkg::*;

  localparam int ST_PRD = 0;
  localparam int ST_SUM = 1;
  localparam int ST_MUL = 2;
  localparam int ST_SQ1 = 3;
  localparam int ST_Q   = ST_SQ1 + SQ1_STEPS;
  localparam int ST_SH  = ST_Q + 1;
  localparam int ST_SQR = ST_SH + 1;
  localparam int ST_ACC = ST_SQR + 1;
  localparam int ST_SQ2 = ST_ACC + 1;
  localparam int ST_NUM = ST_SQ2 + SQ2_STEPS;
  localparam int ST_DIV = ST_NUM + 1;
  localparam int ST_OUT = ST_DIV + DIV_STEPS;
  localparam int NST    = ST_OUT + 1;

  // Item data between the cross product and the first square root.
  typedef struct packed {
    logic [1:0]         code;
    logic signed [33:0] d;
    logic signed [32:0] q1;
    logic signed [32:0] q2;
    logic signed [32:0] q3;
  } hold_t;

  // Item data through the normalisation stages.
  typedef struct packed {
    logic [1:0]        code;
    logic [3:0]        sgn;
    logic [3:0][29:0]  mag;
  } nrm_t;

  // ---------------------------------------------------------------------------
  // Valid bits and per-stage advance
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  assign en[NST-1] = !v_r[NST-1] || out_tready;
  generate
    for (genvar i = 0; i < NST - 1; i++) begin : g_en
      assign en[i] = !v_r[i] || en[i+1];
    end
  endgenerate

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: all products of the two vectors
  // ---------------------------------------------------------------------------
  logic signed [15:0] ax, ay, az, bx, by, bz;
  assign ax = in_tdata[15:0];
  assign ay = in_tdata[31:16];
  assign az = in_tdata[47:32];
  assign bx = in_tdata[63:48];
  assign by = in_tdata[79:64];
  assign bz = in_tdata[95:80];

  logic signed [15:0] a_r [3];
  logic signed [31:0] pc_r [6];
  logic signed [31:0] pd_r [3];
  logic signed [31:0] sa_r [3];
  logic signed [31:0] sb_r [3];
  logic               zero_r;

  always_ff @(posedge clk) begin
    if (en[ST_PRD]) begin
      a_r[0]  <= ax;
      a_r[1]  <= ay;
      a_r[2]  <= az;
      pc_r[0] <= ay * bz;
      pc_r[1] <= az * by;
      pc_r[2] <= az * bx;
      pc_r[3] <= ax * bz;
      pc_r[4] <= ax * by;
      pc_r[5] <= ay * bx;
      pd_r[0] <= ax * bx;
      pd_r[1] <= ay * by;
      pd_r[2] <= az * bz;
      sa_r[0] <= ax * ax;
      sa_r[1] <= ay * ay;
      sa_r[2] <= az * az;
      sb_r[0] <= bx * bx;
      sb_r[1] <= by * by;
      sb_r[2] <= bz * bz;
      zero_r  <= (ax == 16'sd0 && ay == 16'sd0 && az == 16'sd0) ||
                 (bx == 16'sd0 && by == 16'sd0 && bz == 16'sd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: cross and dot products, squared lengths, case decision
  // ---------------------------------------------------------------------------
  logic signed [32:0] c0, c1, c2, na0, na1, na2;
  logic signed [33:0] dsum;
  logic [1:0]         code1;
  logic               czero;
  hold_t              h1;
  hold_t              h1_r;
  logic [31:0]        na_r, nb_r;

  always_comb begin
    c0    = 33'(pc_r[0]) - 33'(pc_r[1]);
    c1    = 33'(pc_r[2]) - 33'(pc_r[3]);
    c2    = 33'(pc_r[4]) - 33'(pc_r[5]);
    dsum  = 34'(pd_r[0]) + 34'(pd_r[1]) + 34'(pd_r[2]);
    czero = (c0 == 33'sd0) && (c1 == 33'sd0) && (c2 == 33'sd0);
    // Axis for opposite vectors: x cross a, or y cross a when that is zero.
    na0   = -33'(a_r[0]);
    na1   = 33'(a_r[1]);
    na2   = -33'(a_r[2]);
    if (zero_r) begin
      code1 = CODE_ZERO;
    end else if (czero) begin
      code1 = (dsum >= 34'sd0) ? CODE_ALIGN : CODE_OPP;
    end else begin
      code1 = CODE_GEN;
    end
    h1.code = code1;
    h1.d    = dsum;
    if (code1 == CODE_GEN) begin
      h1.q1 = c0;
      h1.q2 = c1;
      h1.q3 = c2;
    end else if (a_r[1] == 16'sd0 && a_r[2] == 16'sd0) begin
      h1.q1 = 33'sd0;
      h1.q2 = 33'sd0;
      h1.q3 = na0;
    end else begin
      h1.q1 = 33'sd0;
      h1.q2 = na2;
      h1.q3 = na1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      h1_r <= h1;
      na_r <= $unsigned(sa_r[0]) + $unsigned(sa_r[1]) + $unsigned(sa_r[2]);
      nb_r <= $unsigned(sb_r[0]) + $unsigned(sb_r[1]) + $unsigned(sb_r[2]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: product of the squared lengths
  // ---------------------------------------------------------------------------
  logic [63:0] prod_r;
  hold_t       h2_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      prod_r <= na_r * nb_r;
      h2_r   <= h1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // First square root, one root bit per stage: m = sqrt(|a|^2 |b|^2)
  // ---------------------------------------------------------------------------
  sqrt_t sq1_r [SQ1_STEPS];
  hold_t hs1_r [SQ1_STEPS];

  generate
    for (genvar j = 0; j < SQ1_STEPS; j++) begin : g_sq1
      if (j == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (en[ST_SQ1]) begin
            sq1_r[0] <= sqrt_step('{rem: prod_r, root: 32'd0}, SQ1_STEPS - 1);
            hs1_r[0] <= h2_r;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (en[ST_SQ1+j]) begin
            sq1_r[j] <= sqrt_step(sq1_r[j-1], SQ1_STEPS - 1 - j);
            hs1_r[j] <= hs1_r[j-1];
          end
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Quaternion before normalisation, as sign and magnitude
  // ---------------------------------------------------------------------------
  hold_t              hq;
  logic signed [34:0] q0s;
  logic [33:0]        mq_r [4];
  logic [3:0]         sq_sgn_r;
  logic [1:0]         cq_r;

  assign hq  = hs1_r[SQ1_STEPS-1];
  assign q0s = (hq.code == CODE_GEN) ?
               ($signed({3'b000, sq1_r[SQ1_STEPS-1].root}) + 35'(hq.d)) : 35'sd0;

  always_ff @(posedge clk) begin
    if (en[ST_Q]) begin
      mq_r[0]  <= q0s[33:0];
      mq_r[1]  <= {1'b0, abs33(hq.q1)};
      mq_r[2]  <= {1'b0, abs33(hq.q2)};
      mq_r[3]  <= {1'b0, abs33(hq.q3)};
      sq_sgn_r <= {hq.q3[32], hq.q2[32], hq.q1[32], 1'b0};
      cq_r     <= hq.code;
    end
  end

  // ---------------------------------------------------------------------------
  // Common right shift until every magnitude is below 2^30
  // ---------------------------------------------------------------------------
  logic [3:0] top;
  logic [2:0] shamt;
  nrm_t       nsh;
  nrm_t       nsh_r;

  always_comb begin
    top = 4'((mq_r[0] | mq_r[1] | mq_r[2] | mq_r[3]) >> 30);
    if (top[3]) begin
      shamt = 3'd4;
    end else if (top[2]) begin
      shamt = 3'd3;
    end else if (top[1]) begin
      shamt = 3'd2;
    end else if (top[0]) begin
      shamt = 3'd1;
    end else begin
      shamt = 3'd0;
    end
    nsh.code = cq_r;
    nsh.sgn  = sq_sgn_r;
    for (int i = 0; i < 4; i++) begin
      nsh.mag[i] = 30'(mq_r[i] >> shamt);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SH]) begin
      nsh_r <= nsh;
    end
  end

  // ---------------------------------------------------------------------------
  // Squares of the four parts, then their sum
  // ---------------------------------------------------------------------------
  logic [59:0] psq_r [4];
  nrm_t        nsq_r, nac_r;
  logic [61:0] acc_r;

  always_ff @(posedge clk) begin
    if (en[ST_SQR]) begin
      for (int i = 0; i < 4; i++) begin
        psq_r[i] <= nsh_r.mag[i] * nsh_r.mag[i];
      end
      nsq_r <= nsh_r;
    end
    if (en[ST_ACC]) begin
      acc_r <= 62'(psq_r[0]) + 62'(psq_r[1]) + 62'(psq_r[2]) + 62'(psq_r[3]);
      nac_r <= nsq_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Second square root: the norm n
  // ---------------------------------------------------------------------------
  sqrt_t sq2_r [SQ2_STEPS];
  nrm_t  ns2_r [SQ2_STEPS];

  generate
    for (genvar j = 0; j < SQ2_STEPS; j++) begin : g_sq2
      if (j == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (en[ST_SQ2]) begin
            sq2_r[0] <= sqrt_step('{rem: {2'b00, acc_r}, root: 32'd0}, SQ2_STEPS - 1);
            ns2_r[0] <= nac_r;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (en[ST_SQ2+j]) begin
            sq2_r[j] <= sqrt_step(sq2_r[j-1], SQ2_STEPS - 1 - j);
            ns2_r[j] <= ns2_r[j-1];
          end
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Rounded dividends: part * 2^FRAC + n / 2
  // ---------------------------------------------------------------------------
  logic [30:0] nrt;
  div_t        dn_r [4];
  logic [30:0] nn_r;
  nrm_t        nn_nrm_r;

  assign nrt = sq2_r[SQ2_STEPS-1].root[30:0];

  always_ff @(posedge clk) begin
    if (en[ST_NUM]) begin
      for (int i = 0; i < 4; i++) begin
        dn_r[i].rem <= ({16'd0, ns2_r[SQ2_STEPS-1].mag[i]} << FRAC) + 46'(nrt >> 1);
        dn_r[i].quo <= 15'd0;
      end
      nn_r     <= nrt;
      nn_nrm_r <= ns2_r[SQ2_STEPS-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Four dividers in step, one quotient bit per stage
  // ---------------------------------------------------------------------------
  div_t        dv_r  [DIV_STEPS][4];
  logic [30:0] dvn_r [DIV_STEPS];
  nrm_t        dvm_r [DIV_STEPS];

  generate
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      if (j == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (en[ST_DIV]) begin
            for (int i = 0; i < 4; i++) begin
              dv_r[0][i] <= div_step(dn_r[i], nn_r, DIV_STEPS - 1);
            end
            dvn_r[0] <= nn_r;
            dvm_r[0] <= nn_nrm_r;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (en[ST_DIV+j]) begin
            for (int i = 0; i < 4; i++) begin
              dv_r[j][i] <= div_step(dv_r[j-1][i], dvn_r[j-1], DIV_STEPS - 1 - j);
            end
            dvn_r[j] <= dvn_r[j-1];
            dvm_r[j] <= dvm_r[j-1];
          end
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Output register: cap, restore signs, identity for the special cases
  // ---------------------------------------------------------------------------
  nrm_t             fin;
  logic             ident;
  logic [OUT_W-1:0] rq [4];
  logic [OUT_W-1:0] qo_r [4];
  logic [1:0]       code_o_r;

  assign fin   = dvm_r[DIV_STEPS-1];
  assign ident = (fin.code == CODE_ALIGN) || (fin.code == CODE_ZERO) ||
                 (dvn_r[DIV_STEPS-1] == 31'd0);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rq[i] = {1'b0, dv_r[DIV_STEPS-1][i].quo};
      if (rq[i] > ONE_Q) begin
        rq[i] = ONE_Q;
      end
      if (fin.sgn[i]) begin
        rq[i] = OUT_W'(-rq[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      qo_r[0]  <= ident ? ONE_Q : rq[0];
      for (int i = 1; i < 4; i++) begin
        qo_r[i] <= ident ? '0 : rq[i];
      end
      code_o_r <= fin.code;
    end
  end

  assign out_tdata = {qo_r[3], qo_r[2], qo_r[1], qo_r[0]};
  assign out_tuser = code_o_r;

endmodule
